FILE: src/fmfsc_pkg.sv
// Package: types, codes and the message length table for the feed framer.
`default_nettype none
package fmfsc_pkg;

	localparam int MAX_MESSAGE_BYTES = 40;
	localparam int LEN_W = 6;
	localparam int EVQ_DEPTH = 4;
	localparam int EVQ_AW = $clog2(EVQ_DEPTH);

	localparam logic [7:0] TYPE_S = 8'h53;
	localparam logic [7:0] TYPE_R = 8'h52;
	localparam logic [7:0] TYPE_A = 8'h41;
	localparam logic [7:0] TYPE_F = 8'h46;
	localparam logic [7:0] TYPE_E = 8'h45;
	localparam logic [7:0] TYPE_C = 8'h43;
	localparam logic [7:0] TYPE_X = 8'h58;
	localparam logic [7:0] TYPE_D = 8'h44;
	localparam logic [7:0] TYPE_U = 8'h55;

	localparam logic [2:0] VERDICT_IN_SEQ     = 3'd0;
	localparam logic [2:0] VERDICT_GAP        = 3'd1;
	localparam logic [2:0] VERDICT_DUPLICATE  = 3'd2;
	localparam logic [2:0] VERDICT_UNTRACKED  = 3'd3;
	localparam logic [2:0] VERDICT_UNKNOWN    = 3'd4;
	localparam logic [2:0] VERDICT_INCOMPLETE = 3'd5;

	localparam logic [1:0] EV_DONE    = 2'd0;
	localparam logic [1:0] EV_UNKNOWN = 2'd1;
	localparam logic [1:0] EV_SHORT   = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  message_type;
		logic [15:0] tracking_number;
		logic [2:0]  verdict;
		logic [16:0] expected_before;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  msg_type;
		logic [15:0] tracking;
	} event_t;

	function automatic logic [LEN_W-1:0] length_of(input logic [7:0] t);
		logic [LEN_W-1:0] n;
		unique case (t)
			TYPE_S: n = LEN_W'(12);
			TYPE_R: n = LEN_W'(39);
			TYPE_A: n = LEN_W'(36);
			TYPE_F: n = LEN_W'(40);
			TYPE_E: n = LEN_W'(31);
			TYPE_C: n = LEN_W'(36);
			TYPE_X: n = LEN_W'(23);
			TYPE_D: n = LEN_W'(19);
			TYPE_U: n = LEN_W'(35);
			default: n = '0;
		endcase
		if (n > LEN_W'(MAX_MESSAGE_BYTES))
			n = LEN_W'(MAX_MESSAGE_BYTES);
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: src/fmfsc_front.sv
// Front end: frames packet bytes into messages and raises one event per message.
`default_nettype none
module fmfsc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire fmfsc_pkg::in_item_t item,
	output logic                     ev_push,
	output fmfsc_pkg::event_t        ev
);
	import fmfsc_pkg::*;

	logic [LEN_W-1:0] pos_q;
	logic             discard_q;
	logic [7:0]       type_q;
	logic [LEN_W-1:0] len_q;
	logic [15:0]      trk_q;

	logic [LEN_W-1:0] tbl_len;
	logic [LEN_W-1:0] len_eff;
	logic [7:0]       type_nx;
	logic [15:0]      trk_nx;
	logic [LEN_W:0]   pos_inc;
	logic             is_first;

	assign is_first = (pos_q == '0);
	assign tbl_len  = length_of(item.data_byte);
	assign len_eff  = is_first ? tbl_len : len_q;
	assign type_nx  = is_first ? item.data_byte : type_q;
	assign pos_inc  = {1'b0, pos_q} + (LEN_W+1)'(1);

	always_comb begin
		trk_nx = trk_q;
		if (is_first)
			trk_nx = '0;
		else if (pos_q == LEN_W'(3))
			trk_nx = {item.data_byte, trk_q[7:0]};
		else if (pos_q == LEN_W'(4))
			trk_nx = {trk_q[15:8], item.data_byte};
	end

	always_comb begin
		ev_push     = 1'b0;
		ev.kind     = EV_DONE;
		ev.msg_type = type_nx;
		ev.tracking = trk_nx;
		if (accept && !discard_q) begin
			priority if (is_first && tbl_len == '0) begin
				ev_push     = 1'b1;
				ev.kind     = EV_UNKNOWN;
				ev.tracking = '0;
			end else if (pos_inc >= {1'b0, len_eff}) begin
				ev_push = 1'b1;
			end else if (item.packet_end) begin
				ev_push = 1'b1;
				ev.kind = EV_SHORT;
			end else begin
				ev_push = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			discard_q <= 1'b0;
		end else if (accept) begin
			priority if (discard_q) begin
				if (item.packet_end) begin
					discard_q <= 1'b0;
					pos_q     <= '0;
				end
			end else if (is_first && tbl_len == '0) begin
				discard_q <= !item.packet_end;
			end else if (pos_inc >= {1'b0, len_eff} || item.packet_end) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_inc[LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !discard_q) begin
			type_q <= type_nx;
			trk_q  <= trk_nx;
			if (is_first)
				len_q <= tbl_len;
		end
	end

endmodule
`default_nettype wire

FILE: src/fmfsc_evq.sv
// Event queue: short queue between the framing front end and the sequence judge.
`default_nettype none
module fmfsc_evq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire fmfsc_pkg::event_t din,
	output logic                   full,
	input  wire logic              pop,
	output fmfsc_pkg::event_t      dout,
	output logic                   valid
);
	import fmfsc_pkg::*;

	event_t            mem_q [EVQ_DEPTH];
	logic [EVQ_AW-1:0] wr_q;
	logic [EVQ_AW-1:0] rd_q;
	logic [EVQ_AW:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == (EVQ_AW+1)'(EVQ_DEPTH));
	assign valid   = (cnt_q != '0);
	assign dout    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + EVQ_AW'(1);
			if (do_pop)
				rd_q <= rd_q + EVQ_AW'(1);
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (EVQ_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (EVQ_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= din;
	end

endmodule
`default_nettype wire

FILE: src/fmfsc_back.sv
// Back end: judges tracking numbers against the expected number and holds the result.
`default_nettype none
module fmfsc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fmfsc_pkg::event_t ev,
	input  wire logic              ev_valid,
	output logic                   ev_pop,
	output fmfsc_pkg::out_item_t   result,
	output logic                   empty,
	input  wire logic              pop
);
	import fmfsc_pkg::*;

	logic [16:0] exp_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic [2:0]  verdict;
	logic [16:0] exp_nx;
	logic [16:0] trk_ext;

	assign trk_ext = {1'b0, ev.tracking};
	assign ev_pop  = ev_valid && (!out_valid_q || pop);
	assign empty   = !out_valid_q;
	assign result  = out_q;

	always_comb begin
		exp_nx  = exp_q;
		verdict = VERDICT_IN_SEQ;
		unique case (ev.kind)
			EV_UNKNOWN: verdict = VERDICT_UNKNOWN;
			EV_SHORT:   verdict = VERDICT_INCOMPLETE;
			EV_DONE: begin
				priority if (ev.tracking == '0) begin
					verdict = VERDICT_UNTRACKED;
				end else if (trk_ext < exp_q) begin
					verdict = VERDICT_DUPLICATE;
				end else if (trk_ext > exp_q) begin
					verdict = VERDICT_GAP;
					exp_nx  = trk_ext + 17'd1;
				end else begin
					verdict = VERDICT_IN_SEQ;
					exp_nx  = exp_q + 17'd1;
				end
			end
			default: verdict = VERDICT_IN_SEQ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q       <= 17'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (ev_pop) begin
				exp_q       <= exp_nx;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_pop) begin
			out_q.message_type    <= ev.msg_type;
			out_q.tracking_number <= ev.tracking;
			out_q.verdict         <= verdict;
			out_q.expected_before <= exp_q;
		end
	end

endmodule
`default_nettype wire

FILE: src/feed_message_framer_sequence_check.sv
// Top level of the feed message framer and sequence checker.
// Takes one packet byte per cycle (push/full) and frames it into fixed-length
// messages by type byte; each completed message, unknown type or packet cut
// short yields one result (empty/pop) carrying the type, the big-endian
// tracking number from bytes 3-4, a verdict and the expected number before the
// judgement. Sustained rate is one byte per cycle while results are popped:
// framing is done in the front end as each byte is taken, results are judged
// one per cycle in the back end while its output register is free or popped,
// and a four-entry event queue plus the output register hold up to five
// results waiting to be popped; once the queue fills, full stops input. A
// result goes through the event queue, then the output register. After an
// unknown type the rest of the packet is dropped without results.
`default_nettype none
module feed_message_framer_sequence_check (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire fmfsc_pkg::in_item_t item,
	output logic                     full,
	input  wire logic                pop,
	output fmfsc_pkg::out_item_t     result,
	output logic                     empty
);
	import fmfsc_pkg::*;

	logic   accept;
	logic   ev_push;
	event_t ev_in;
	event_t ev_out;
	logic   ev_valid;
	logic   ev_pop;

	assign accept = push && !full;

	fmfsc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.ev_push (ev_push),
		.ev      (ev_in)
	);

	fmfsc_evq u_evq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ev_push),
		.din    (ev_in),
		.full   (full),
		.pop    (ev_pop),
		.dout   (ev_out),
		.valid  (ev_valid)
	);

	fmfsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev       (ev_out),
		.ev_valid (ev_valid),
		.ev_pop   (ev_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule
`default_nettype wire

FILE: dv/feed_message_framer_sequence_check_test.sv
// Self-checking testbench for the feed message framer and sequence checker.
module feed_message_framer_sequence_check_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fmfsc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int BYTE_TARGET = 1950;

	class feed_ledger;
		out_item_t   verdicts_due[$];
		logic [16:0] next_seq;
		logic [5:0]  msg_pos;
		logic [5:0]  msg_len;
		logic [7:0]  msg_type;
		logic [15:0] msg_trk;
		bit          skip_packet;
		int          bytes_taken;
		int          results_seen;
		int          faults;
		int          per_verdict[6];

		function new();
			next_seq = 17'd1;
			msg_pos = '0;
			msg_len = '0;
			msg_type = '0;
			msg_trk = '0;
			skip_packet = 1'b0;
			bytes_taken = 0;
			results_seen = 0;
			faults = 0;
			foreach (per_verdict[i])
				per_verdict[i] = 0;
		endfunction

		static function int length_for(logic [7:0] kind);
			int n;
			case (kind)
				TYPE_S: n = 12;
				TYPE_R: n = 39;
				TYPE_A: n = 36;
				TYPE_F: n = 40;
				TYPE_E: n = 31;
				TYPE_C: n = 36;
				TYPE_X: n = 23;
				TYPE_D: n = 19;
				TYPE_U: n = 35;
				default: n = 0;
			endcase
			if (n > MAX_MESSAGE_BYTES)
				n = MAX_MESSAGE_BYTES;
			return n;
		endfunction

		function void log_verdict(logic [7:0] kind, logic [15:0] trk, logic [2:0] v);
			out_item_t e;
			e.message_type = kind;
			e.tracking_number = trk;
			e.verdict = v;
			e.expected_before = next_seq;
			verdicts_due.push_back(e);
		endfunction

		function void take_byte(in_item_t octet);
			int n;
			bytes_taken++;
			if (skip_packet) begin
				if (octet.packet_end) begin
					skip_packet = 1'b0;
					msg_pos = '0;
				end
				return;
			end
			if (msg_pos == 0) begin
				n = length_for(octet.data_byte);
				if (n == 0) begin
					log_verdict(octet.data_byte, 16'h0000, VERDICT_UNKNOWN);
					skip_packet = !octet.packet_end;
					return;
				end
				msg_type = octet.data_byte;
				msg_len = 6'(n);
				msg_trk = '0;
			end else if (msg_pos == 3) begin
				msg_trk[15:8] = octet.data_byte;
			end else if (msg_pos == 4) begin
				msg_trk[7:0] = octet.data_byte;
			end
			if (int'(msg_pos) + 1 >= int'(msg_len)) begin
				msg_pos = '0;
				if (msg_trk == 16'h0000) begin
					log_verdict(msg_type, msg_trk, VERDICT_UNTRACKED);
				end else if (17'(msg_trk) < next_seq) begin
					log_verdict(msg_type, msg_trk, VERDICT_DUPLICATE);
				end else if (17'(msg_trk) > next_seq) begin
					log_verdict(msg_type, msg_trk, VERDICT_GAP);
					next_seq = 17'(msg_trk) + 17'd1;
				end else begin
					log_verdict(msg_type, msg_trk, VERDICT_IN_SEQ);
					next_seq = next_seq + 17'd1;
				end
				return;
			end
			if (octet.packet_end) begin
				msg_pos = '0;
				log_verdict(msg_type, msg_trk, VERDICT_INCOMPLETE);
				return;
			end
			msg_pos = msg_pos + 6'd1;
		endfunction

		function void match_verdict(out_item_t got);
			out_item_t want;
			if (verdicts_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: type %02h trk %04h verdict %0d exp %05h",
						got.message_type, got.tracking_number, got.verdict,
						got.expected_before);
				return;
			end
			want = verdicts_due.pop_front();
			results_seen++;
			per_verdict[want.verdict]++;
			if (got.message_type !== want.message_type ||
				got.tracking_number !== want.tracking_number ||
				got.verdict !== want.verdict ||
				got.expected_before !== want.expected_before) begin
				faults++;
				if (faults <= 10) begin
					$display("result %0d mismatch: expected type %02h trk %04h verdict %0d exp %05h",
						results_seen, want.message_type, want.tracking_number,
						want.verdict, want.expected_before);
					$display("                     actual type %02h trk %04h verdict %0d exp %05h",
						got.message_type, got.tracking_number, got.verdict,
						got.expected_before);
				end
			end
		endfunction

		function int waiting();
			return verdicts_due.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      push;
	in_item_t  item;
	logic      full;
	logic      pop;
	out_item_t result;
	logic      empty;

	feed_ledger ledger = new();
	bit feed_calm = 1'b0;
	bit take_calm = 1'b0;
	int plan_seq = 1;
	int bytes_sent = 0;
	int cycles = 0;

	feed_message_framer_sequence_check u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.pop    (pop),
		.result (result),
		.empty  (empty)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				ledger.waiting());
			$display("feed_message_framer_sequence_check verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				ledger.take_byte(item);
			if (pop && !empty)
				ledger.match_verdict(result);
		end
	end

	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 63) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic logic [7:0] pick_type();
		logic [7:0] known[9];
		int roll;
		known = '{TYPE_S, TYPE_R, TYPE_A, TYPE_F, TYPE_E, TYPE_C, TYPE_X, TYPE_D, TYPE_U};
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return TYPE_S;
		if (roll < 60)
			return TYPE_D;
		return known[$urandom_range(0, 8)];
	endfunction

	function automatic logic [7:0] pick_unknown();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (feed_ledger::length_for(b) != 0);
		return b;
	endfunction

	function automatic logic [15:0] pick_tracking();
		int roll;
		int t;
		roll = $urandom_range(0, 99);
		if (roll < 62 || plan_seq < 2) begin
			t = plan_seq;
			plan_seq++;
		end else if (roll < 77) begin
			t = plan_seq + $urandom_range(1, 40);
			plan_seq = t + 1;
		end else if (roll < 90) begin
			t = $urandom_range(1, plan_seq - 1);
		end else begin
			t = 0;
		end
		return 16'(t);
	endfunction

	task automatic push_byte(input logic [7:0] b, input bit last);
		int gap;
		gap = draw_gap(feed_calm);
		if (gap > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		item <= '{data_byte: b, packet_end: last};
		do
			@(posedge clk);
		while (full);
	endtask

	// stop_at below the last byte cuts the packet short there
	task automatic frame_message(input logic [7:0] kind, input logic [15:0] trk,
		input int stop_at, input bit closes);
		int n;
		logic [7:0] b;
		bit last;
		n = feed_ledger::length_for(kind);
		if (stop_at > n - 1)
			stop_at = n - 1;
		for (int i = 0; i <= stop_at; i++) begin
			case (i)
				0: b = kind;
				3: b = trk[15:8];
				4: b = trk[7:0];
				default: b = 8'($urandom_range(0, 255));
			endcase
			last = (i == stop_at) && (closes || stop_at < n - 1);
			push_byte(b, last);
		end
		bytes_sent += stop_at + 1;
	endtask

	task automatic reject_packet(input logic [7:0] kind, input int tail);
		push_byte(kind, tail == 0);
		for (int i = 1; i <= tail; i++)
			push_byte(8'($urandom_range(0, 255)), i == tail);
		bytes_sent += tail + 1;
	endtask

	task automatic feed_bytes();
		int msgs;
		int roll;
		logic [7:0] kind;
		frame_message(TYPE_S, 16'd1, 63, 1'b1);
		frame_message(TYPE_R, 16'd2, 63, 1'b0);
		frame_message(TYPE_A, 16'd3, 63, 1'b0);
		frame_message(TYPE_F, 16'd4, 63, 1'b0);
		frame_message(TYPE_E, 16'd5, 63, 1'b0);
		frame_message(TYPE_C, 16'd6, 63, 1'b0);
		frame_message(TYPE_X, 16'd7, 63, 1'b0);
		frame_message(TYPE_D, 16'd8, 63, 1'b0);
		frame_message(TYPE_U, 16'd9, 63, 1'b1);
		frame_message(TYPE_S, 16'd20, 63, 1'b1);
		frame_message(TYPE_D, 16'd5, 63, 1'b0);
		frame_message(TYPE_X, 16'd0, 63, 1'b1);
		reject_packet(8'h00, 0);
		reject_packet(8'hFF, 3);
		frame_message(TYPE_S, 16'hFFFF, 0, 1'b1);
		frame_message(TYPE_A, 16'hAB12, 3, 1'b1);
		frame_message(TYPE_C, 16'h12CD, 4, 1'b1);
		frame_message(TYPE_F, 16'h7777, 38, 1'b1);
		frame_message(TYPE_S, 16'd21, 63, 1'b1);
		frame_message(TYPE_S, 16'd22, 63, 1'b0);
		reject_packet(8'h5A, 2);
		plan_seq = 23;

		while (bytes_sent < BYTE_TARGET) begin
			msgs = $urandom_range(1, 4);
			for (int m = 1; m <= msgs; m++) begin
				roll = $urandom_range(0, 99);
				if (m < msgs || roll < 76) begin
					frame_message(pick_type(), pick_tracking(), 63, m == msgs);
				end else if (roll < 88) begin
					kind = pick_type();
					frame_message(kind, 16'($urandom),
						$urandom_range(0, feed_ledger::length_for(kind) - 2), 1'b1);
				end else if (roll < 95) begin
					reject_packet(pick_unknown(), $urandom_range(0, 3));
				end else begin
					reject_packet(pick_unknown(), $urandom_range(4, 40));
				end
			end
		end

		// drive the expected number to its ceiling
		frame_message(TYPE_S, 16'hFFFE, 63, 1'b1);
		frame_message(TYPE_S, 16'hFFFF, 63, 1'b1);
		frame_message(TYPE_S, 16'hFFFF, 63, 1'b0);
		frame_message(TYPE_D, 16'h0001, 63, 1'b0);
		frame_message(TYPE_S, 16'h0000, 63, 1'b0);
		frame_message(TYPE_E, 16'h8000, 63, 1'b1);
		frame_message(TYPE_X, 16'h4321, 6, 1'b1);
	endtask

	task automatic take_results();
		int gap;
		forever begin
			gap = draw_gap(take_calm);
			if (gap > 0) begin
				@(negedge clk) pop <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		fork
			feed_bytes();
			take_results();
		join_any
		@(negedge clk) push <= 1'b0;
		while (ledger.waiting() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		$display("%0d byte transfers in, %0d results checked, %0d mismatches",
			ledger.bytes_taken, ledger.results_seen, ledger.faults);
		$display("in sequence %0d, gap %0d, duplicate %0d, untracked %0d, unknown %0d, incomplete %0d",
			ledger.per_verdict[VERDICT_IN_SEQ], ledger.per_verdict[VERDICT_GAP],
			ledger.per_verdict[VERDICT_DUPLICATE], ledger.per_verdict[VERDICT_UNTRACKED],
			ledger.per_verdict[VERDICT_UNKNOWN], ledger.per_verdict[VERDICT_INCOMPLETE]);
		if (ledger.faults == 0 && ledger.waiting() == 0)
			$display("feed_message_framer_sequence_check verification clean");
		else
			$display("feed_message_framer_sequence_check verification failed");
		$finish;
	end

endmodule
